FILE: hw/rtl/psfp_pkg.sv
// package: constants and types for the particle sensor frame parser
`timescale 1ns / 1ps
package psfp_pkg;

	localparam int FRAME_BYTES     = 32;
	localparam int POS_W           = $clog2(FRAME_BYTES);
	localparam int VALUE_COUNT     = 12;
	localparam int VALUE_W         = 16;
	localparam int BYTE_W          = 8;
	localparam int IDX_W           = $clog2(VALUE_COUNT);
	localparam int FIRST_VALUE_POS = 4;

	localparam logic [BYTE_W-1:0]  HDR_FIRST  = 8'h42;
	localparam logic [BYTE_W-1:0]  HDR_SECOND = 8'h4D;
	localparam logic [VALUE_W-1:0] HDR_SUM    = 16'h008F;

	localparam logic [POS_W-1:0] POS_SUM_END  = POS_W'(FRAME_BYTES - 2);
	localparam logic [POS_W-1:0] POS_LAST     = POS_W'(FRAME_BYTES - 1);
	localparam logic [POS_W-1:0] POS_FIRST_LO = POS_W'(FIRST_VALUE_POS + 1);
	localparam logic [POS_W-1:0] POS_VAL_BASE = POS_W'(FIRST_VALUE_POS);
	localparam logic [POS_W-1:0] POS_AFTER_HDR1 = POS_W'(1);
	localparam logic [POS_W-1:0] POS_AFTER_HDR2 = POS_W'(2);

	typedef logic [VALUE_COUNT-1:0][VALUE_W-1:0] meas_t;

	typedef struct packed {
		logic  valid;
		meas_t values;
	} result_t;

endpackage

FILE: hw/rtl/psfp_byte_if.sv
// interface: received byte channel
`timescale 1ns / 1ps
interface psfp_byte_if;
	import psfp_pkg::*;

	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface

FILE: hw/rtl/psfp_meas_if.sv
// interface: measurement result channel
`timescale 1ns / 1ps
interface psfp_meas_if;
	import psfp_pkg::*;

	logic               valid;
	logic               ready;
	logic [VALUE_W-1:0] pm1p0_standard;
	logic [VALUE_W-1:0] pm2p5_standard;
	logic [VALUE_W-1:0] pm10_standard;
	logic [VALUE_W-1:0] pm1p0_atmos;
	logic [VALUE_W-1:0] pm2p5_atmos;
	logic [VALUE_W-1:0] pm10_atmos;
	logic [VALUE_W-1:0] count_0p3;
	logic [VALUE_W-1:0] count_0p5;
	logic [VALUE_W-1:0] count_1p0;
	logic [VALUE_W-1:0] count_2p5;
	logic [VALUE_W-1:0] count_5p0;
	logic [VALUE_W-1:0] count_10;

	modport source (output valid, input ready, output pm1p0_standard, output pm2p5_standard,
		output pm10_standard, output pm1p0_atmos, output pm2p5_atmos, output pm10_atmos,
		output count_0p3, output count_0p5, output count_1p0, output count_2p5,
		output count_5p0, output count_10);
	modport sink (input valid, output ready, input pm1p0_standard, input pm2p5_standard,
		input pm10_standard, input pm1p0_atmos, input pm2p5_atmos, input pm10_atmos,
		input count_0p3, input count_0p5, input count_1p0, input count_2p5,
		input count_5p0, input count_10);
endinterface

FILE: hw/rtl/particle_sensor_frame_parser.sv
// top level: particle sensor serial frame parser
//
//  port   dir   payload                               item
//  rx     sink  rx_byte [7:0]                         one received byte
//  meas   src   twelve 16-bit measurements            one checked frame
//
// one byte per cycle unless a held result stalls the parser; a byte waits in
// the input register until the parser folds it into the frame state
// the last byte's result reaches meas via the input and result registers
// reset clears phase, position, sum, held byte and both valid flags
// a held result stalls the parser, and rx.ready drops once the input
// register is also full
`timescale 1ns / 1ps
module particle_sensor_frame_parser
	import psfp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	psfp_byte_if.sink   rx,
	psfp_meas_if.source meas
);

	logic              vld_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              free;
	logic              take;
	result_t           result;

	assign take = vld_s1 && free;

	psfp_in_reg u_in_reg (
		.clk     (clk),
		.arst_n  (arst_n),
		.rx      (rx),
		.take    (take),
		.vld_s1  (vld_s1),
		.byte_s1 (byte_s1)
	);

	psfp_parser u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.take    (take),
		.byte_s1 (byte_s1),
		.result  (result)
	);

	psfp_out_reg u_out_reg (
		.clk    (clk),
		.arst_n (arst_n),
		.result (result),
		.free   (free),
		.meas   (meas)
	);

endmodule

FILE: hw/rtl/psfp_in_reg.sv
// input register: holds one received byte until the parser takes it
`timescale 1ns / 1ps
module psfp_in_reg
	import psfp_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	psfp_byte_if.sink         rx,
	input  logic              take,
	output logic              vld_s1,
	output logic [BYTE_W-1:0] byte_s1
);

	logic accept;

	assign rx.ready = !vld_s1 || take;
	assign accept   = rx.valid && rx.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (accept) begin
			vld_s1 <= 1'b1;
		end else if (take) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_s1 <= rx.rx_byte;
		end
	end

endmodule

FILE: hw/rtl/psfp_parser.sv
// frame parser: header hunt, checksum sum and measurement capture
`timescale 1ns / 1ps
module psfp_parser
	import psfp_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              take,
	input  logic [BYTE_W-1:0] byte_s1,
	output result_t           result
);

	typedef enum logic [1:0] {
		PH_HUNT,
		PH_GOT_FIRST,
		PH_BODY
	} phase_t;

	phase_t              phase_q, phase_d;
	logic [POS_W-1:0]    pos_q, pos_d;
	logic [VALUE_W-1:0]  sum_q, sum_d;
	logic [BYTE_W-1:0]   held_q, held_d;
	meas_t               values_q;
	logic                wr_en;
	logic [POS_W-1:0]    val_off;
	logic [IDX_W-1:0]    wr_idx;
	logic [VALUE_W-1:0]  pair;
	logic                good;

	assign pair    = {held_q, byte_s1};
	assign val_off = pos_q - POS_VAL_BASE;
	assign wr_idx  = val_off[IDX_W:1];

	always_comb begin
		phase_d = phase_q;
		pos_d   = pos_q;
		sum_d   = sum_q;
		held_d  = held_q;
		wr_en   = 1'b0;
		good    = 1'b0;
		case (phase_q)
			PH_GOT_FIRST: begin
				if (byte_s1 == HDR_SECOND) begin
					phase_d = PH_BODY;
					sum_d   = HDR_SUM;
					pos_d   = POS_AFTER_HDR2;
				end else if (byte_s1 != HDR_FIRST) begin
					phase_d = PH_HUNT;
					pos_d   = '0;
					sum_d   = '0;
					held_d  = '0;
				end
			end
			PH_BODY: begin
				if (pos_q == POS_LAST) begin
					good    = (pair == sum_q);
					phase_d = PH_HUNT;
					pos_d   = '0;
					sum_d   = '0;
					held_d  = '0;
				end else begin
					if (pos_q < POS_SUM_END) begin
						sum_d = sum_q + VALUE_W'(byte_s1);
					end
					if (!pos_q[0]) begin
						held_d = byte_s1;
					end else if (pos_q >= POS_FIRST_LO && val_off[POS_W-1:1] <
						(POS_W-1)'(VALUE_COUNT)) begin
						wr_en = 1'b1;
					end
					pos_d = pos_q + 1'b1;
				end
			end
			default: begin
				pos_d  = '0;
				sum_d  = '0;
				held_d = '0;
				if (byte_s1 == HDR_FIRST) begin
					phase_d = PH_GOT_FIRST;
					pos_d   = POS_AFTER_HDR1;
				end else begin
					phase_d = PH_HUNT;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			pos_q   <= '0;
			sum_q   <= '0;
			held_q  <= '0;
		end else if (take) begin
			phase_q <= phase_d;
			pos_q   <= pos_d;
			sum_q   <= sum_d;
			held_q  <= held_d;
		end
	end

	always_ff @(posedge clk) begin
		if (take && wr_en) begin
			values_q[wr_idx] <= pair;
		end
	end

	assign result.valid  = take && good;
	assign result.values = values_q;

endmodule

FILE: hw/rtl/psfp_out_reg.sv
// result register: holds one measurement set until the sink takes it
`timescale 1ns / 1ps
module psfp_out_reg
	import psfp_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  result_t    result,
	output logic       free,
	psfp_meas_if.source meas
);

	logic  vld_q;
	meas_t values_q;

	assign free = !vld_q || meas.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (result.valid) begin
			vld_q <= 1'b1;
		end else if (meas.ready) begin
			vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (result.valid) begin
			values_q <= result.values;
		end
	end

	assign meas.valid          = vld_q;
	assign meas.pm1p0_standard = values_q[0];
	assign meas.pm2p5_standard = values_q[1];
	assign meas.pm10_standard  = values_q[2];
	assign meas.pm1p0_atmos    = values_q[3];
	assign meas.pm2p5_atmos    = values_q[4];
	assign meas.pm10_atmos     = values_q[5];
	assign meas.count_0p3      = values_q[6];
	assign meas.count_0p5      = values_q[7];
	assign meas.count_1p0      = values_q[8];
	assign meas.count_2p5      = values_q[9];
	assign meas.count_5p0      = values_q[10];
	assign meas.count_10       = values_q[11];

endmodule
